// ===== rtl/plst_pkg.sv =====
// Shared types, codes and defaults for the positional list engine.
`timescale 1ns / 1ps

package plst_pkg;

    // Default list capacity and entry width
    localparam int PLST_CAPACITY = 32;
    localparam int PLST_DATA_W   = 32;

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_BADPOS = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    // Command transaction
    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         position;
        logic signed [31:0] value;
    } cmd_t;

    // Result transaction
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic               element_valid;
        logic               last;
        logic [5:0]         count;
    } rsp_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_INS_PUT,
        ST_DEL,
        ST_DUMP
    } state_t;

endpackage

// ===== rtl/plst_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module plst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/positional_list_engine_unit.sv =====
// Top level of the positional list engine: sequencer around the entry RAM.
`timescale 1ns / 1ps

// Channel  | Ports                 | Handshake
// ---------+-----------------------+------------------------------------------
// command  | start, busy, cmd      | taken at a rising edge with start & !busy
// result   | result_valid, result  | one-cycle strobe, receiver cannot stall
//
// Entries live in one RAM with a registered read; shifts run one
// entry per cycle (read at one address, write the previous read one place on).
// Insert at the tail writes at once, else it shifts entries back from the tail
//   down to position, then writes the value; delete at the tail only drops the
//   count, else it shifts later entries forward; dump emits entries in order.
// Reset clears the entry count and the sequencer; RAM contents need no reset.
// busy is high while a shift, its final write or a dump runs; results are never held back.

module positional_list_engine_unit #(
    parameter int CAPACITY = plst_pkg::PLST_CAPACITY
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  plst_pkg::cmd_t cmd,
    output logic           result_valid,
    output plst_pkg::rsp_t result
);

    import plst_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [CW-1:0]           count_reg, count_next;
    logic signed [31:0]      val_reg, val_next;
    rsp_t                    rsp_reg, rsp_next;
    logic                    rsp_vld_reg, rsp_vld_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [PLST_DATA_W-1:0]  ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [PLST_DATA_W-1:0]  ram_rdata;

    logic [CMPW-1:0]         pos_ext;
    logic [CMPW-1:0]         cnt_ext;
    logic                    ins_bad;
    logic                    is_full;
    logic                    is_empty;
    logic                    del_bad;
    logic                    ins_at_end;
    logic                    del_at_end;
    logic [AW-1:0]           tail_addr;
    logic [AW-1:0]           del_first;
    logic                    idx_last;

    // Entry store
    plst_ram #(
        .WIDTH (PLST_DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Classify the incoming command against the current count
    always_comb
    begin
        pos_ext    = CMPW'(cmd.position);
        cnt_ext    = CMPW'(count_reg);
        ins_bad    = pos_ext > cnt_ext;
        is_full    = count_reg == CW'(CAPACITY);
        is_empty   = count_reg == '0;
        del_bad    = pos_ext >= cnt_ext;
        ins_at_end = pos_ext == cnt_ext;
        del_at_end = pos_ext == (cnt_ext - CMPW'(1));
        tail_addr  = AW'(count_reg - CW'(1));
        del_first  = AW'(cmd.position) + AW'(1);
        idx_last   = CW'(idx_reg) == (count_reg - CW'(1));
    end

    // Next state, index, count and held operands
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        val_next   = val_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    pos_next = AW'(cmd.position);
                    val_next = cmd.value;
                    case (cmd.operation)
                        OP_INSERT:
                        begin
                            if (!ins_bad && !is_full)
                            begin
                                if (ins_at_end)
                                begin
                                    count_next = count_reg + CW'(1);
                                end
                                else
                                begin
                                    state_next = ST_INS;
                                    idx_next   = tail_addr;
                                end
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!is_empty && !del_bad)
                            begin
                                if (del_at_end)
                                begin
                                    count_next = count_reg - CW'(1);
                                end
                                else
                                begin
                                    state_next = ST_DEL;
                                    idx_next   = del_first;
                                end
                            end
                        end
                        OP_DUMP:
                        begin
                            if (!is_empty)
                            begin
                                state_next = ST_DUMP;
                                idx_next   = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INS:
            begin
                if (idx_reg == pos_reg)
                begin
                    state_next = ST_INS_PUT;
                end
                else
                begin
                    idx_next = idx_reg - AW'(1);
                end
            end
            ST_INS_PUT:
            begin
                count_next = count_reg + CW'(1);
                state_next = ST_IDLE;
            end
            ST_DEL:
            begin
                if (idx_last)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_DUMP:
            begin
                if (idx_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // RAM accesses and the next result
    always_comb
    begin
        ram_we                 = 1'b0;
        ram_waddr              = '0;
        ram_wdata              = ram_rdata;
        ram_re                 = 1'b0;
        ram_raddr              = '0;
        rsp_vld_next           = 1'b0;
        rsp_next.status        = STAT_OK;
        rsp_next.element       = '0;
        rsp_next.element_valid = 1'b0;
        rsp_next.last          = 1'b1;
        rsp_next.count         = 6'(count_next);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.operation)
                        OP_INSERT:
                        begin
                            if (ins_bad)
                            begin
                                rsp_vld_next    = 1'b1;
                                rsp_next.status = STAT_BADPOS;
                            end
                            else if (is_full)
                            begin
                                rsp_vld_next    = 1'b1;
                                rsp_next.status = STAT_FULL;
                            end
                            else if (ins_at_end)
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = AW'(cmd.position);
                                ram_wdata    = cmd.value;
                                rsp_vld_next = 1'b1;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = tail_addr;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (is_empty)
                            begin
                                rsp_vld_next    = 1'b1;
                                rsp_next.status = STAT_EMPTY;
                            end
                            else if (del_bad)
                            begin
                                rsp_vld_next    = 1'b1;
                                rsp_next.status = STAT_BADPOS;
                            end
                            else if (del_at_end)
                            begin
                                rsp_vld_next = 1'b1;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = del_first;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (is_empty)
                            begin
                                rsp_vld_next    = 1'b1;
                                rsp_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                            end
                        end
                        default:
                        begin
                            rsp_vld_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_INS:
            begin
                // move the entry just read one place back
                ram_we    = 1'b1;
                ram_waddr = idx_reg + AW'(1);
                if (idx_reg != pos_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg - AW'(1);
                end
            end
            ST_INS_PUT:
            begin
                ram_we       = 1'b1;
                ram_waddr    = pos_reg;
                ram_wdata    = val_reg;
                rsp_vld_next = 1'b1;
            end
            ST_DEL:
            begin
                // move the entry just read one place forward
                ram_we    = 1'b1;
                ram_waddr = idx_reg - AW'(1);
                if (idx_last)
                begin
                    rsp_vld_next = 1'b1;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + AW'(1);
                end
            end
            ST_DUMP:
            begin
                rsp_vld_next           = 1'b1;
                rsp_next.element       = ram_rdata;
                rsp_next.element_valid = 1'b1;
                rsp_next.last          = idx_last;
                if (!idx_last)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + AW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        val_reg <= val_next;
        rsp_reg <= rsp_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign result_valid = rsp_vld_reg;
    assign result       = rsp_reg;

endmodule
